// ===== hdl/kes_pkg.sv =====
package kes_pkg;

	// Forest size and field widths
	localparam int NODES     = 65536;
	localparam int ID_W      = 16;
	localparam int W_W       = 13;
	localparam int SUM_W     = 28;
	localparam int RANK_W    = 5;

	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
	localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

	// One entry of the forest memory: rank of the node (meaningful for roots
	// only) and its parent link.
	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [ID_W-1:0]   parent;
	} node_word_t;

	// Sequencer states
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CLEAR = 6'b000010,
		ST_CHKN  = 6'b000100,
		ST_CHKU  = 6'b001000,
		ST_MERGE = 6'b010000,
		ST_RANK  = 6'b100000
	} state_t;

endpackage

// ===== hdl/kruskal_edge_select_core.sv =====
// Edge selection for a minimum spanning forest over a union-find forest held
// in one single-port-write, single-port-read memory. After reset the block
// runs a clearing pass over all 65536 nodes (one node per cycle) with busy
// high. An edge is taken when start is high and busy is low; busy then stays
// high until the edge is finished, and its result appears on selected and
// forest_weight, marked by done, which is high for a single cycle. The
// receiver cannot stall, so it must take the result in that cycle. The block
// walks the parent hops from each end node to its root through the
// registered memory read, halving the path as it goes, and raises the rank of
// the new root when two roots of equal rank are joined. An edge with an end
// node outside the forest is answered from the idle state without a walk,
// with busy staying low, and reports selected low.
module kruskal_edge_select_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [kes_pkg::ID_W-1:0]   end_a,
	input  logic [kes_pkg::ID_W-1:0]   end_b,
	input  logic [kes_pkg::W_W-1:0]    edge_weight,
	output logic                       done,
	output logic                       selected,
	output logic [kes_pkg::SUM_W-1:0]  forest_weight
);
	import kes_pkg::*;

	state_t            state_q;
	logic              phase_q;
	logic [ID_W-1:0]   node_q;
	logic [ID_W-1:0]   b_q;
	logic [W_W-1:0]    w_q;
	logic [ID_W-1:0]   ra_q;
	logic [ID_W-1:0]   rb_q;
	logic [RANK_W-1:0] rka_q;
	logic [RANK_W-1:0] rkb_q;
	logic [ID_W-1:0]   clr_q;
	logic [SUM_W-1:0]  sum_q;
	logic              done_q;
	logic              sel_q;

	node_word_t        mem [NODES];
	node_word_t        rd_q;

	logic              re;
	logic [ID_W-1:0]   raddr;
	logic              we;
	logic [ID_W-1:0]   waddr;
	node_word_t        wdata;

	logic              accept;
	logic              in_range;
	logic [SUM_W:0]    sum_add;
	logic [SUM_W-1:0]  sum_next;

	assign accept   = start && (state_q == ST_IDLE);
	assign in_range = (32'(end_a) < NODES) && (32'(end_b) < NODES);

	// Saturating update of the running total with the held weight.
	assign sum_add  = {1'b0, sum_q} + (SUM_W+1)'(w_q);
	assign sum_next = (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[SUM_W-1:0];

	// Forest memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// Memory port control, decoded from the sequencer state.
	always_comb begin
		re    = 1'b0;
		raddr = node_q;
		we    = 1'b0;
		waddr = node_q;
		wdata = '{rank: '0, parent: node_q};
		case (state_q)
			ST_IDLE: begin
				re    = accept && in_range;
				raddr = end_a;
			end
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '{rank: '0, parent: clr_q};
			end
			ST_CHKN: begin
				if (rd_q.parent != node_q) begin
					// Not a root: fetch the grandparent.
					re    = 1'b1;
					raddr = rd_q.parent;
				end else if (!phase_q) begin
					// First root found: start the walk from the other end.
					re    = 1'b1;
					raddr = b_q;
				end
			end
			ST_CHKU: begin
				// Path halving: point the node at its grandparent and move there.
				we    = 1'b1;
				waddr = node_q;
				wdata = '{rank: '0, parent: rd_q.parent};
				re    = 1'b1;
				raddr = rd_q.parent;
			end
			ST_MERGE: begin
				if (ra_q != rb_q) begin
					we = 1'b1;
					if (rka_q < rkb_q) begin
						waddr = ra_q;
						wdata = '{rank: rka_q, parent: rb_q};
					end else begin
						waddr = rb_q;
						wdata = '{rank: rkb_q, parent: ra_q};
					end
				end
			end
			ST_RANK: begin
				we    = 1'b1;
				waddr = ra_q;
				wdata = '{rank: (rka_q == RANK_MAX) ? rka_q : rka_q + 1'b1, parent: ra_q};
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	// Sequencer and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			phase_q <= 1'b0;
			clr_q   <= '0;
			sum_q   <= '0;
			done_q  <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_range) begin
							state_q <= ST_CHKN;
							phase_q <= 1'b0;
						end else begin
							done_q <= 1'b1;
							sel_q  <= 1'b0;
						end
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == NODES - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CHKN: begin
					if (rd_q.parent != node_q) begin
						state_q <= ST_CHKU;
					end else if (!phase_q) begin
						phase_q <= 1'b1;
					end else begin
						state_q <= ST_MERGE;
					end
				end
				ST_CHKU: begin
					state_q <= ST_CHKN;
				end
				ST_MERGE: begin
					if (ra_q == rb_q) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						sel_q   <= 1'b0;
					end else begin
						sum_q <= sum_next;
						sel_q <= 1'b1;
						if (rka_q == rkb_q) begin
							state_q <= ST_RANK;
						end else begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				ST_RANK: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Edge operands, walk pointer and the two roots found.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					node_q <= end_a;
					b_q    <= end_b;
					w_q    <= edge_weight;
				end
			end
			ST_CHKN: begin
				if (rd_q.parent == node_q) begin
					if (!phase_q) begin
						ra_q   <= node_q;
						rka_q  <= rd_q.rank;
						node_q <= b_q;
					end else begin
						rb_q  <= node_q;
						rkb_q <= rd_q.rank;
					end
				end
			end
			ST_CHKU: begin
				node_q <= rd_q.parent;
			end
			default: begin
				node_q <= node_q;
			end
		endcase
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign selected      = sel_q;
	assign forest_weight = sum_q;

endmodule
